// ----- design/aes128_ctr_cipher_top_assert.svh -----
// Assertion macros shared by the AES-128 counter mode design.
`ifndef AES128_CTR_CIPHER_TOP_ASSERT_SVH
`define AES128_CTR_CIPHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ACT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ACT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/act_pkg.sv -----
// Package with types, constants and AES functions for the counter mode cipher.
package act_pkg;
    typedef struct packed {
        logic [63:0] data_upper;
        logic [63:0] data_lower;
        logic        first_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
    } t_out_item;

    // Request handed from the front part to the cipher pipeline.
    typedef struct packed {
        logic [127:0] data;
        logic [127:0] ctr_block;
    } t_job;

    typedef enum logic [1:0] {
        CFG_KEY_UPPER  = 2'd0,
        CFG_KEY_LOWER  = 2'd1,
        CFG_NONCE_WORD = 2'd2
    } t_cfg_idx;

    localparam int unsigned ROUNDS = 10;
    localparam logic [7:0] XTIME_POLY = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Round constants for rounds one to ten.
    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return b[7] ? ({b[6:0], 1'b0} ^ XTIME_POLY) : {b[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Next round key from the previous one; the state byte 0 is in bits 127:120.
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96] ^ (sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0});
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        t  = w3;
        return {w0, w1, w2, t};
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                t[4*c+q] = b[4*((c+q)%4)+q];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (last) begin
                r[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                r[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                     a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        return r;
    endfunction
endpackage

// ----- design/act_front.sv -----
// Front part: accepts data requests, keeps the block counter, forms counter blocks.
module act_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_nonce,
    input  logic              i_valid,
    output logic              o_ready,
    input  act_pkg::t_in_item i_item,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output act_pkg::t_job     o_job
);
    import act_pkg::*;

    logic [63:0] r_counter, n_counter, w_ctr;
    logic        w_take;

    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign w_take      = i_valid && i_job_ready;
    assign w_ctr       = i_item.first_block ? 64'd0 : r_counter;
    assign o_job.data      = {i_item.data_upper, i_item.data_lower};
    assign o_job.ctr_block = {i_nonce, w_ctr};
    assign n_counter   = w_ctr + 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (w_take) begin
            r_counter <= n_counter;
        end
    end

    `include "aes128_ctr_cipher_top_assert.svh"
    `ACT_ASSERT_NEXT(a_ctr_step, i_clk, i_rst_n, w_take, r_counter == $past(w_ctr) + 64'd1, "counter did not advance")
    `ACT_ASSERT_NEXT(a_ctr_hold, i_clk, i_rst_n, !w_take, $stable(r_counter), "counter moved without a request")
    `ACT_ASSERT_IMP(a_first_zero, i_clk, i_rst_n, i_valid && i_item.first_block, o_job.ctr_block[63:0] == 64'd0, "first block counter not zero")
endmodule

// ----- design/act_fifo.sv -----
// Short two-entry queue between the front part and the cipher pipeline.
module act_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  act_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output act_pkg::t_job o_job
);
    import act_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `include "aes128_ctr_cipher_top_assert.svh"
    `ACT_ASSERT_IMP(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count out of range")
    `ACT_ASSERT_NEXT(a_fifo_ptr, i_clk, i_rst_n, 1'b1, (r_cnt == 2'd1) == (r_wp != r_rp), "queue pointers disagree with count")
endmodule

// ----- design/act_core.sv -----
// Back part: AES pipeline of a key addition stage and ten round stages, with round keys travelling alongside the state.
module act_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [127:0]    i_key,
    input  logic            i_valid,
    output logic            o_ready,
    input  act_pkg::t_job   i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output act_pkg::t_out_item o_item
);
    import act_pkg::*;

    logic [127:0] r_state [ROUNDS+1];
    logic [127:0] r_rkey  [ROUNDS+1];
    logic [127:0] r_data  [ROUNDS+1];
    logic         r_vld   [ROUNDS+1];
    logic         w_adv   [ROUNDS+1];
    logic [127:0] w_out;

    // Stage 0 takes the counter block after the first key addition;
    // the last stage is the output register.
    always_comb begin
        w_adv[ROUNDS] = !r_vld[ROUNDS] || i_ready;
        for (int s = ROUNDS - 1; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[ROUNDS];
    assign w_out   = r_data[ROUNDS] ^ r_state[ROUNDS];
    assign o_item  = '{result_upper: w_out[127:64], result_lower: w_out[63:0]};

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_state[0] <= i_job.ctr_block ^ i_key;
            r_rkey[0]  <= i_key;
            r_data[0]  <= i_job.data;
        end
        for (int s = 1; s <= ROUNDS; s++) begin
            if (w_adv[s]) begin
                r_rkey[s]  <= next_round_key(r_rkey[s-1], RCON[s-1]);
                r_state[s] <= aes_round(r_state[s-1], s == ROUNDS)
                              ^ next_round_key(r_rkey[s-1], RCON[s-1]);
                r_data[s]  <= r_data[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ROUNDS; s++) r_vld[s] <= 1'b0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            for (int s = 1; s <= ROUNDS; s++) begin
                if (w_adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    `include "aes128_ctr_cipher_top_assert.svh"
    `ACT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(w_out), "result changed while stalled")
endmodule

// ----- design/aes128_ctr_cipher_top.sv -----
// AES-128 counter mode block: request channel, result channel and key/nonce registers.
// Usage:
//   Write key_upper (index 0), key_lower (1) and nonce_word (2) through the
//   write port while the block is idle. Each input request carries a 128-bit
//   data block and a first-block flag; the flag restarts the block counter at
//   zero. The keystream is AES-128 of {nonce, counter} and is XORed into the
//   data, so the same request serves encryption and decryption.
//   From input acceptance to a valid result, the request is written into
//   the queue, taken from it by the key addition stage, then passes ten
//   round stages, the last of which is the output register.
//   Throughput is one block per cycle unless the receiver stalls; the ten
//   round stages, which expand the round keys alongside the data, set it.
//   When the receiver stalls the pipeline holds its result and fills up;
//   the two-entry queue then fills and input ready falls.
//   Reset (synchronous, active low) clears the key, nonce and counter and
//   empties the pipeline.
module aes128_ctr_cipher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  act_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output act_pkg::t_out_item  o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);
    import act_pkg::*;

    logic [63:0] r_key_upper, r_key_lower, r_nonce;
    logic        w_jv, w_jr, w_qv, w_qr;
    t_job        w_job, w_qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_nonce     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_UPPER:  r_key_upper <= i_cfg_data;
                CFG_KEY_LOWER:  r_key_lower <= i_cfg_data;
                CFG_NONCE_WORD: r_nonce     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    act_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_nonce(r_nonce),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_data),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    act_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_jv), .o_ready(w_jr), .i_job(w_job),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qjob)
    );

    act_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key({r_key_upper, r_key_lower}),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qjob),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_data)
    );
endmodule

// ----- dv/tb_aes128_ctr_cipher_top.sv -----
// Self-checking testbench for the AES-128 counter mode block with random flow control.
module tb_aes128_ctr_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;
    import act_pkg::*;

    // Keystream predictor and queue of expected result blocks.
    class ctr_keystream_board;
        logic [63:0] key_hi, key_lo, nonce, counter;
        logic [31:0] rk [44];
        t_out_item   pending [$];
        int          mismatches, checked;

        function void clear();
            key_hi = '0; key_lo = '0; nonce = '0; counter = '0;
            pending.delete();
            expand();
        endfunction

        function logic [7:0] dbl(logic [7:0] b);
            return b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
        endfunction

        function void expand();
            logic [7:0]  rc;
            logic [31:0] t;
            rc = 8'h01;
            rk[0] = key_hi[63:32]; rk[1] = key_hi[31:0];
            rk[2] = key_lo[63:32]; rk[3] = key_lo[31:0];
            for (int i = 4; i < 44; i++) begin
                t = rk[i-1];
                if (i % 4 == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]}
                        ^ {rc, 24'h0};
                    rc = dbl(rc);
                end
                rk[i] = rk[i-4] ^ t;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] val);
            case (idx)
                CFG_KEY_UPPER: begin key_hi = val; expand(); end
                CFG_KEY_LOWER: begin key_lo = val; expand(); end
                CFG_NONCE_WORD: nonce = val;
                default: ;
            endcase
        endfunction

        function logic [127:0] encrypt(logic [127:0] blk);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, al;
            logic [127:0] r;
            for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
            for (int rnd = 0; rnd <= 10; rnd++) begin
                if (rnd > 0) begin
                    for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
                    for (int c = 0; c < 4; c++)
                        for (int q = 0; q < 4; q++) t[4*c+q] = s[4*((c+q)%4)+q];
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        if (rnd == 10) begin
                            s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                        end else begin
                            al = a0 ^ a1 ^ a2 ^ a3;
                            s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                            s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                            s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                            s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                        end
                    end
                end
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++) s[4*c+q] ^= rk[4*rnd+c][31-8*q -: 8];
            end
            for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
            return r;
        endfunction

        function void note_request(t_in_item it);
            logic [127:0] ks;
            t_out_item    e;
            if (it.first_block) counter = '0;
            ks = encrypt({nonce, counter});
            counter = counter + 64'd1;
            e.result_upper = it.data_upper ^ ks[127:64];
            e.result_lower = it.data_lower ^ ks[63:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.result_upper !== e.result_upper || got.result_lower !== e.result_lower)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch %0d: expected %h_%h, got %h_%h", checked,
                             e.result_upper, e.result_lower,
                             got.result_upper, got.result_lower);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0, i_rst_n = 1'b0;
    logic        i_valid = 1'b0, i_ready = 1'b0, i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    t_in_item    i_data = '0;
    logic        o_ready, o_valid;
    t_out_item   o_data;

    ctr_keystream_board board;
    int  idle_cycles, sent;
    bit  stall_on = 1'b1;

    aes128_ctr_cipher_top DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver stalls in its own runs; periods without stalls keep full rate.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) board.check_result(o_data);
        i_ready <= !stall_on || ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 2000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Holds the request until accepted; gaps between requests are chosen by the caller.
    task automatic send_request(logic [63:0] hi, logic [63:0] lo, logic first, int gap);
        t_in_item it;
        it.data_upper = hi; it.data_lower = lo; it.first_block = first;
        i_valid <= 1'b1; i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(it);
        sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_burst(int n);
        int burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) burst = $urandom_range(1, 16);
            burst--;
            send_request(rand64(), rand64(), $urandom_range(0, 15) == 0,
                         burst == 0 ? $urandom_range(0, 6) : 0);
        end
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero key and nonce straight after reset, counter running from zero.
        send_request('0, '0, 1'b0, 0);
        send_request('1, '1, 1'b0, 0);
        send_request(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1);
        drain();

        // Standard test key with all-ones upper and zero lower data, with counter restarts.
        write_reg(CFG_KEY_UPPER, 64'h2b7e151628aed2a6);
        write_reg(CFG_KEY_LOWER, 64'habf7158809cf4f3c);
        write_reg(CFG_NONCE_WORD, 64'hf0f1f2f3f4f5f6f7);
        for (int k = 0; k < 6; k++)
            send_request('1, '0, k == 3, 0);
        send_request(64'h8000000000000000, 64'h1, 1'b1, 0);
        drain();

        // The counter wrap itself is out of reach in a run, so this phase checks a
        // restart followed by ordinary blocks with an all-ones key and nonce.
        write_reg(CFG_KEY_UPPER, '1);
        write_reg(CFG_KEY_LOWER, '1);
        write_reg(CFG_NONCE_WORD, '1);
        for (int k = 0; k < 8; k++) send_request(rand64(), rand64(), k == 0, 0);
        drain();

        // Random phases with fresh keys and nonces, but a zero key in the last and the nonce kept in the third.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_KEY_UPPER, ph == 5 ? 64'h0 : rand64());
            write_reg(CFG_KEY_LOWER, ph == 5 ? 64'h0 : rand64());
            if (ph != 2) write_reg(CFG_NONCE_WORD, rand64());
            random_burst(100);
            drain();
        end

        $display("Sent %0d blocks over several key and nonce settings, %0d results checked.",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/act_pkg.sv
design/act_front.sv
design/act_fifo.sv
design/act_core.sv
design/aes128_ctr_cipher_top.sv
dv/tb_aes128_ctr_cipher_top.sv
